@@ hw/rtl/asc_pkg.sv @@
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the approximate substring search
// Holds the widths, command and register codes, the controller states, the
// structs that travel along the row of distance cells, and the case fold.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int PATTERN_MAX = 64;
    // Wide enough to hold any distance up to and including PATTERN_MAX.
    localparam int DIST_W      = $clog2(PATTERN_MAX + 1);
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 6;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 7;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int PCT_MAX     = 100;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_LENGTH  = 1'b0,
        CFG_PERCENT = 1'b1
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // Wavefront handed from one cell to the next.
    typedef struct packed {
        logic              tok;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] diag;
    } t_link;

    // Broadcast control seen by every cell.
    typedef struct packed {
        logic              restart;
        logic              load;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] pchar;
        logic [CHAR_W-1:0] text;
        logic [DIST_W-1:0] len;
    } t_cell_ctrl;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/asc_cmd_if.sv @@
// ----------------------------------------------------------------------------
// asc_cmd_if: command channel
// Carries one command word: the command code, a pattern position and a byte.
// ----------------------------------------------------------------------------
interface asc_cmd_if import asc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_value;

    modport source (output valid, output command, output position, output char_value,
                    input ready);
    modport sink   (input valid, input command, input position, input char_value,
                    output ready);
endinterface

@@ hw/rtl/asc_res_if.sv @@
// ----------------------------------------------------------------------------
// asc_res_if: result channel
// Carries one result word: hit flag, sticky found flag and end distance.
// ----------------------------------------------------------------------------
interface asc_res_if import asc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              match_here;
    logic              found;
    logic [DIST_W-1:0] end_distance;

    modport source (output valid, output match_here, output found, output end_distance,
                    input ready);
    modport sink   (input valid, input match_here, input found, input end_distance,
                    output ready);
endinterface

@@ hw/rtl/asc_cell.sv @@
// ----------------------------------------------------------------------------
// asc_cell: one row of the edit-distance column
// Holds one pattern byte and one column entry. When the wavefront token
// arrives it computes the new entry and hands it on to the next cell.
// ----------------------------------------------------------------------------
module asc_cell import asc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIST_W-1:0] i_index,
    input  t_cell_ctrl        i_ctrl,
    input  t_link             i_link,
    output t_link             o_link
);

    logic [CHAR_W-1:0] r_pchar;
    logic [DIST_W-1:0] r_dist;
    logic              r_tok;
    logic [DIST_W-1:0] r_left;
    logic [DIST_W-1:0] r_diag;

    logic              w_en;
    logic              w_act;
    logic [DIST_W-1:0] w_min;
    logic [DIST_W-1:0] w_val;

    // Cells beyond the pattern length keep their entries and swallow the token.
    assign w_en  = (i_index <= i_ctrl.len);
    assign w_act = i_link.tok && w_en;

    always_comb begin
        w_min = i_link.left;
        if (i_link.diag < w_min) begin
            w_min = i_link.diag;
        end
        if (r_dist < w_min) begin
            w_min = r_dist;
        end
        if (i_ctrl.text == r_pchar) begin
            w_val = i_link.diag;
        end else begin
            w_val = w_min + DIST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= i_index;
            r_tok  <= 1'b0;
        end else begin
            r_tok <= w_act;
            if (i_ctrl.restart) begin
                r_dist <= i_index;
            end else if (w_act) begin
                r_dist <= w_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= w_val;
        r_diag <= r_dist;
        if (i_ctrl.load && (DIST_W'(i_ctrl.pos) == i_index - DIST_W'(1))) begin
            r_pchar <= i_ctrl.pchar;
        end
    end

    assign o_link.tok  = r_tok;
    assign o_link.left = r_left;
    assign o_link.diag = r_diag;

endmodule

@@ hw/rtl/approximate_substring_search.sv @@
// ----------------------------------------------------------------------------
// approximate_substring_search: streaming approximate pattern search
// Keeps a pattern of up to 64 bytes and an edit-distance column, and reports
// for every text byte whether an approximate occurrence ends there.
//
// Usage: configure pattern_length (index 0) and error_percent (index 1) on the
// write port while the block is idle. Send words on i_cmd: load a pattern byte
// at a position, restart the search, or feed a text byte. Every command word
// produces exactly one word on o_res. Byte compares fold ASCII upper case.
//
// Timing: a text byte runs as a token down the row of cells, one cell per
// cycle, and the block takes no new word until the result of that byte has
// been computed. Load, restart, unused codes and text with an empty pattern
// skip the row. The single output register lets a new command word be taken
// while the previous result still waits.
// Reset clears the column to the 0..j ramp, the found flag and both
// configuration registers; pattern bytes are undefined until loaded. When the
// receiver stalls, a finished result waits and no further word is taken.
// ----------------------------------------------------------------------------
module approximate_substring_search import asc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    asc_cmd_if.sink           i_cmd,
    asc_res_if.source         o_res
);

    t_state            r_state, n_state;
    logic [DIST_W-1:0] r_cnt, n_cnt;
    logic [CHAR_W-1:0] r_text;
    logic              r_found, n_found;
    logic              r_pend_match, n_pend_match;
    logic              r_pend_found, n_pend_found;
    logic [DIST_W-1:0] r_pend_dist, n_pend_dist;
    logic              r_ov, n_ov;
    logic              r_o_match;
    logic              r_o_found;
    logic [DIST_W-1:0] r_o_dist;
    logic [CFG_W-1:0]  r_len;
    logic [CFG_W-1:0]  r_pct;
    logic [PROD_W-1:0] r_prod;

    logic              w_acc;
    t_cmd              w_cmd;
    logic [DIST_W-1:0] w_len;
    logic [CFG_W-1:0]  w_pct;
    logic              w_slot_free;
    logic [DIST_W-1:0] w_end;
    logic              w_hit;
    t_cell_ctrl        w_ctrl;
    t_link             w_link [0:PATTERN_MAX];
    logic [PATTERN_MAX:0] w_tok;

    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign w_cmd       = t_cmd'(i_cmd.command);
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign w_slot_free = !r_ov || o_res.ready;

    assign w_len = (r_len > CFG_W'(PATTERN_MAX)) ? DIST_W'(PATTERN_MAX) : DIST_W'(r_len);
    assign w_pct = (r_pct > CFG_W'(PCT_MAX)) ? CFG_W'(PCT_MAX) : r_pct;

    // floor(prod / 100) >= dist is the same test as prod >= 100 * dist.
    assign w_end = w_link[w_len].left;
    assign w_hit = (PROD_W'(w_end) * PROD_W'(PCT_MAX)) <= r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pct <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg'(i_cfg_idx))
                CFG_LENGTH:  r_len <= i_cfg_wdata;
                CFG_PERCENT: r_pct <= i_cfg_wdata;
                default:     r_len <= r_len;
            endcase
        end
    end

    // The product settles well before any scan can finish.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_pct) * PROD_W'(w_len);
    end

    always_comb begin
        w_ctrl.restart = w_acc && (w_cmd == CMD_RESTART);
        w_ctrl.load    = w_acc && (w_cmd == CMD_LOAD);
        w_ctrl.pos     = i_cmd.position;
        w_ctrl.pchar   = fold_case(i_cmd.char_value);
        w_ctrl.text    = r_text;
        w_ctrl.len     = w_len;
    end

    // Entry zero of the column is always zero.
    assign w_link[0].tok  = (r_state == ST_SCAN) && (r_cnt == '0);
    assign w_link[0].left = '0;
    assign w_link[0].diag = '0;
    assign w_tok[0]       = w_link[0].tok;

    for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
        asc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (DIST_W'(j)),
            .i_ctrl  (w_ctrl),
            .i_link  (w_link[j-1]),
            .o_link  (w_link[j])
        );
        assign w_tok[j] = w_link[j].tok;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_found      = r_found;
        n_pend_match = r_pend_match;
        n_pend_found = r_pend_found;
        n_pend_dist  = r_pend_dist;
        n_ov         = r_ov && !o_res.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_pend_match = 1'b0;
                    n_pend_found = r_found;
                    n_pend_dist  = '0;
                    n_state      = ST_HOLD;
                    case (w_cmd)
                        CMD_RESTART: begin
                            n_found      = 1'b0;
                            n_pend_found = 1'b0;
                        end
                        CMD_TEXT: begin
                            if (w_len == '0) begin
                                n_found      = 1'b1;
                                n_pend_match = 1'b1;
                                n_pend_found = 1'b1;
                            end else begin
                                n_cnt   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_found = r_found;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + DIST_W'(1);
                // The cell at the pattern length has just written its entry.
                if (r_cnt == w_len) begin
                    n_found      = r_found || w_hit;
                    n_pend_match = w_hit;
                    n_pend_found = r_found || w_hit;
                    n_pend_dist  = w_end;
                    n_state      = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_match <= n_pend_match;
        r_pend_found <= n_pend_found;
        r_pend_dist  <= n_pend_dist;
        if (w_acc) begin
            r_text <= fold_case(i_cmd.char_value);
        end
        if (r_state == ST_HOLD && w_slot_free) begin
            r_o_match <= r_pend_match;
            r_o_found <= r_pend_found;
            r_o_dist  <= r_pend_dist;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.match_here   = r_o_match;
    assign o_res.found        = r_o_found;
    assign o_res.end_distance = r_o_dist;

    // At most one wavefront travels down the row.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one token in the cell row");

    // The scan counter never runs past the pattern length.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt <= w_len))
        else $error("scan counter passed the pattern length");

    // A reported hit always carries the sticky flag.
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.match_here) |-> o_res.found)
        else $error("hit reported without found flag");

    // A restart clears the found flag.
    a_restart_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd == CMD_RESTART) |=> !r_found)
        else $error("found flag survived a restart");

endmodule

@@ verif/tb_approximate_substring_search.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_approximate_substring_search: self-checking bench for the pattern search
// Drives command words (pattern loads, restarts, text bytes, the unused code)
// and predicts every result word with an edit-distance column kept here.
// Covers empty and full-length patterns, case folding at the letter
// boundaries, length changes in the middle of a search, and clamped register
// values. Runs under three mixes of sender and receiver idling and one long
// output stall.
// ----------------------------------------------------------------------------
module tb_approximate_substring_search;
    import asc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic              match_here;
        logic              found;
        logic [DIST_W-1:0] end_distance;
    } t_report;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;

    asc_cmd_if cmd_bus ();
    asc_res_if res_bus ();

    approximate_substring_search DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    // Mirror of the search state.
    logic [CHAR_W-1:0] pattern_mirror [PATTERN_MAX];
    int                column_mirror  [PATTERN_MAX+1];
    logic              found_mirror;
    logic [CFG_W-1:0]  length_reg;
    logic [CFG_W-1:0]  percent_reg;

    t_report expected_reports [$];
    t_report want;

    int failures;
    int n_words;
    int n_text;
    int n_hits;
    int n_restarts;
    int n_loads;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic int active_span();
        return (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
    endfunction

    function automatic void ramp_column();
        int j;
        for (j = 0; j <= PATTERN_MAX; j++) begin
            column_mirror[j] = j;
        end
    endfunction

    // Advances the mirrored column by one command word and returns its report.
    function automatic t_report advance_search(input t_cmd cmd,
                                               input logic [POS_W-1:0] pos,
                                               input logic [CHAR_W-1:0] ch);
        t_report           r;
        int                span;
        int                pct;
        int                allowed;
        int                diag;
        int                left;
        int                up;
        int                val;
        int                j;
        logic [CHAR_W-1:0] t;
        r = '0;
        case (cmd)
            CMD_LOAD: begin
                pattern_mirror[pos] = ch;
            end
            CMD_RESTART: begin
                ramp_column();
                found_mirror = 1'b0;
            end
            CMD_TEXT: begin
                span    = active_span();
                pct     = (percent_reg > PCT_MAX) ? PCT_MAX : int'(percent_reg);
                allowed = (pct * span) / PCT_MAX;
                if (span == 0) begin
                    r.match_here = 1'b1;
                end else begin
                    t    = lower_ascii(ch);
                    diag = column_mirror[0];
                    left = 0;
                    column_mirror[0] = 0;
                    for (j = 1; j <= span; j++) begin
                        up = column_mirror[j];
                        if (t == lower_ascii(pattern_mirror[j-1])) begin
                            val = diag;
                        end else begin
                            val = left;
                            if (val > diag) val = diag;
                            if (val > up) val = up;
                            val = val + 1;
                        end
                        column_mirror[j] = val;
                        diag = up;
                        left = val;
                    end
                    r.end_distance = DIST_W'(column_mirror[span]);
                    r.match_here   = (column_mirror[span] <= allowed);
                end
                if (r.match_here) found_mirror = 1'b1;
            end
            default: ;
        endcase
        r.found = found_mirror;
        return r;
    endfunction

    // Offers one command word and records its report once it is taken.
    task automatic send_command(input t_cmd cmd, input logic [POS_W-1:0] pos,
                                input logic [CHAR_W-1:0] ch);
        t_report r;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= cmd;
        cmd_bus.position   <= pos;
        cmd_bus.char_value <= ch;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        r = advance_search(cmd, pos, ch);
        expected_reports.push_back(r);
        n_words++;
        if (cmd == CMD_TEXT) n_text++;
        if (cmd == CMD_RESTART) n_restarts++;
        if (cmd == CMD_LOAD) n_loads++;
        if (r.match_here) n_hits++;
    endtask

    task automatic send_text(input logic [CHAR_W-1:0] ch);
        send_command(CMD_TEXT, POS_W'($urandom), ch);
    endtask

    // Stops offering words, waits for every report, then lets the row settle.
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (PATTERN_MAX + 8) @(posedge i_clk);
    endtask

    task automatic configure_search(input logic [CFG_W-1:0] len,
                                    input logic [CFG_W-1:0] pct);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_LENGTH;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_PERCENT;
        i_cfg_wdata <= pct;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        length_reg  = len;
        percent_reg = pct;
    endtask

    // A copy of the pattern with random case and occasional edits.
    task automatic send_occurrence();
        int j;
        int m;
        for (j = 0; j < active_span(); j++) begin
            m = $urandom_range(99);
            if (m < 6) begin
                continue;
            end else if (m < 12) begin
                send_text(CHAR_W'($urandom_range(255)));
            end else if (m < 16) begin
                send_text(CHAR_W'($urandom_range(255)));
                send_text(pattern_mirror[j]);
            end else begin
                send_text($urandom_range(1) ? flip_case(pattern_mirror[j])
                                            : pattern_mirror[j]);
            end
        end
    endtask

    // Mostly near-occurrences of the pattern, with noise and other commands.
    task automatic scan_traffic(input int words);
        int start;
        int r;
        int span;
        start = n_words;
        while (n_words - start < words) begin
            r    = $urandom_range(99);
            span = active_span();
            if (r < 55) begin
                send_occurrence();
            end else if (r < 88) begin
                if (span > 0 && $urandom_range(1)) begin
                    send_text(flip_case(pattern_mirror[$urandom_range(span - 1)]));
                end else begin
                    send_text(CHAR_W'($urandom_range(255)));
                end
            end else if (r < 93) begin
                send_command(CMD_RESTART, POS_W'($urandom), CHAR_W'($urandom_range(255)));
            end else if (r < 97) begin
                send_command(CMD_LOAD, POS_W'($urandom), CHAR_W'($urandom_range(255)));
            end else begin
                send_command(CMD_NONE, POS_W'($urandom), CHAR_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_empty_pattern();
        send_text(8'h00);
        send_command(CMD_NONE, 6'd63, 8'hFF);
        send_command(CMD_RESTART, 6'd0, 8'h00);
    endtask

    // Letters fold, the neighbors of the letter ranges do not.
    task automatic test_case_folding();
        send_command(CMD_LOAD, 6'd0, "z");
        send_command(CMD_LOAD, 6'd1, "@");
        send_command(CMD_LOAD, 6'd2, 8'hFF);
        send_command(CMD_LOAD, 6'd3, "A");
        send_command(CMD_LOAD, 6'd63, 8'h00);
        drain();
        configure_search(7'd4, 7'd25);
        send_command(CMD_RESTART, 6'd21, 8'h5A);
        send_text("Z");
        send_text("@");
        send_text(8'hFF);
        send_text("a");
        send_text(8'h60);
        send_text("[");
        send_text(8'h00);
        send_command(CMD_NONE, 6'd63, 8'hFF);
    endtask

    // Entries beyond the new length keep their values across the change.
    task automatic test_length_change();
        drain();
        configure_search(7'd2, 7'd100);
        send_text("z");
        send_text("@");
        drain();
        configure_search(7'd4, 7'd0);
        send_text(8'hFF);
        send_text("A");
    endtask

    task automatic test_pattern_fill();
        int j;
        for (j = 0; j < PATTERN_MAX; j++) begin
            if ($urandom_range(1)) begin
                send_command(CMD_LOAD, POS_W'(j),
                             CHAR_W'($urandom_range(1) ? "a" + $urandom_range(25)
                                                       : "A" + $urandom_range(25)));
            end else begin
                send_command(CMD_LOAD, POS_W'(j), CHAR_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random_scan(input int shift, input int big_len, input int big_pct);
        int lens [9];
        int pcts [9];
        int k;
        lens = '{1, 2, 3, 5, 6, 8, 12, 0, 16};
        pcts = '{0, 50, 34, 127, 20, 25, 10, 77, 99};
        for (k = 0; k < 9; k++) begin
            drain();
            configure_search(CFG_W'(lens[k]), CFG_W'(pcts[(k + shift) % 9]));
            if ($urandom_range(1)) send_command(CMD_RESTART, POS_W'($urandom), 8'h00);
            scan_traffic(30);
        end
        drain();
        configure_search(CFG_W'(big_len), CFG_W'(big_pct));
        send_command(CMD_RESTART, POS_W'($urandom), 8'h00);
        scan_traffic(20);
    endtask

    // The receiver stalls long enough for the block to refuse further words.
    task automatic test_backpressure();
        drain();
        configure_search(7'd6, 7'd34);
        send_command(CMD_RESTART, 6'd0, 8'h00);
        hold_request = 400;
        scan_traffic(40);
    endtask

    task automatic test_quiet_pause();
        scan_traffic(20);
        drain();
        scan_traffic(20);
    endtask

    // Receiver: random ready, or a counted hold when one is requested.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                res_bus.ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result word with none expected, actual %0d/%0d/%0d", $time,
                         res_bus.match_here, res_bus.found, res_bus.end_distance);
                failures++;
            end else begin
                want = expected_reports.pop_front();
                if (res_bus.match_here !== want.match_here) begin
                    $display("%0t: match_here mismatch, expected %0d, actual %0d", $time,
                             want.match_here, res_bus.match_here);
                    failures++;
                end
                if (res_bus.found !== want.found) begin
                    $display("%0t: found mismatch, expected %0d, actual %0d", $time,
                             want.found, res_bus.found);
                    failures++;
                end
                if (res_bus.end_distance !== want.end_distance) begin
                    $display("%0t: end_distance mismatch, expected %0d, actual %0d", $time,
                             want.end_distance, res_bus.end_distance);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("tb_approximate_substring_search failed");
            $finish;
        end
    end

    initial begin
        failures      = 0;
        n_words       = 0;
        n_text        = 0;
        n_hits        = 0;
        n_restarts    = 0;
        n_loads       = 0;
        hold_request  = 0;
        idle_cycles   = 0;
        length_reg    = '0;
        percent_reg   = '0;
        found_mirror  = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 86;
        ramp_column();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_LENGTH;
        i_cfg_wdata        <= '0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.command    <= CMD_NONE;
        cmd_bus.position   <= '0;
        cmd_bus.char_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_case_folding();
        test_length_change();
        test_pattern_fill();
        test_random_scan(0, 64, 100);
        test_backpressure();

        send_idle_pct = 86;
        recv_idle_pct = 25;
        test_random_scan(3, 127, 127);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_scan(6, 100, 0);
        test_quiet_pause();

        drain();
        $display("Checked %0d command words: %0d text bytes (%0d hits), %0d restarts, %0d loads.",
                 n_words, n_text, n_hits, n_restarts, n_loads);
        $display("Lengths 0 to 127 and percents 0 to 127, three idle mixes, one long stall.");
        if (failures == 0) begin
            $display("tb_approximate_substring_search passed");
        end else begin
            $display("tb_approximate_substring_search failed");
        end
        $finish;
    end

endmodule
